// ===== rtl/svtt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and breakpoint tables for the sensor voltage to temperature unit.
package svtt_pkg;

    localparam int PT_CNT      = 19;
    localparam int SEG_CNT     = PT_CNT - 1;
    localparam int MV_W        = 13;
    localparam int SEG_W       = 5;
    localparam int TEMP_OUT_W  = 14;
    localparam int DEGF_W      = 10;
    localparam int DT_W        = 6;
    localparam int DEN_W       = 10;
    localparam int DIFF_W      = 10;
    localparam int PROD_W      = 14;
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 18;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    typedef logic [MV_W-1:0]  t_mv;
    typedef logic [SEG_W-1:0] t_seg;

    typedef struct packed {
        t_seg k;
        logic clamped;
    } t_tag;

    typedef struct packed {
        t_mv  v;
        t_tag tag;
    } t_seg_item;

    localparam t_mv V_MIN_MV = 13'd120;
    localparam t_mv V_MAX_MV = 13'd4890;

    localparam t_mv BP_MV [PT_CNT] = '{
        13'd120,  13'd200,  13'd300,  13'd360,  13'd470,  13'd610,  13'd800,
        13'd1040, 13'd1350, 13'd1720, 13'd2160, 13'd2620, 13'd3060, 13'd3700,
        13'd3970, 13'd4420, 13'd4870, 13'd4890, 13'd4910
    };

    localparam logic signed [DEGF_W-1:0] BP_DEGF [PT_CNT] = '{
        10'sd302, 10'sd267, 10'sd250, 10'sd230, 10'sd212, 10'sd194, 10'sd176,
        10'sd158, 10'sd140, 10'sd122, 10'sd104, 10'sd86,  10'sd68,  10'sd50,
        10'sd32,  10'sd14,  -10'sd4,  -10'sd22, -10'sd40
    };

    // temperature drop across each segment
    localparam logic [DT_W-1:0] SEG_DT [SEG_CNT] = '{
        6'd35, 6'd17, 6'd20, 6'd18, 6'd18, 6'd18, 6'd18, 6'd18, 6'd18,
        6'd18, 6'd18, 6'd18, 6'd18, 6'd18, 6'd18, 6'd18, 6'd18, 6'd18
    };

    // voltage width of each segment
    localparam logic [DEN_W-1:0] SEG_DEN [SEG_CNT] = '{
        10'd80,  10'd100, 10'd60,  10'd110, 10'd140, 10'd190, 10'd240, 10'd310, 10'd370,
        10'd440, 10'd460, 10'd440, 10'd640, 10'd270, 10'd450, 10'd450, 10'd20,  10'd20
    };

    // floor(2^RECIP_SHIFT / width); quotient estimate is low by at most one
    localparam logic [RECIP_W-1:0] SEG_RECIP [SEG_CNT] = '{
        RECIP_W'((2**RECIP_SHIFT) / 80),  RECIP_W'((2**RECIP_SHIFT) / 100),
        RECIP_W'((2**RECIP_SHIFT) / 60),  RECIP_W'((2**RECIP_SHIFT) / 110),
        RECIP_W'((2**RECIP_SHIFT) / 140), RECIP_W'((2**RECIP_SHIFT) / 190),
        RECIP_W'((2**RECIP_SHIFT) / 240), RECIP_W'((2**RECIP_SHIFT) / 310),
        RECIP_W'((2**RECIP_SHIFT) / 370), RECIP_W'((2**RECIP_SHIFT) / 440),
        RECIP_W'((2**RECIP_SHIFT) / 460), RECIP_W'((2**RECIP_SHIFT) / 440),
        RECIP_W'((2**RECIP_SHIFT) / 640), RECIP_W'((2**RECIP_SHIFT) / 270),
        RECIP_W'((2**RECIP_SHIFT) / 450), RECIP_W'((2**RECIP_SHIFT) / 450),
        RECIP_W'((2**RECIP_SHIFT) / 20),  RECIP_W'((2**RECIP_SHIFT) / 20)
    };

endpackage

// ===== rtl/sensor_voltage_to_temperature_unit.sv =====
`timescale 1ns / 1ps
// Top level: coolant sensor voltage to temperature, piecewise linear interpolation.
//
// Input stream (s_axis): one sensor voltage in millivolts per request, tdata[12:0].
// The voltage is clamped to 120..4890 mV and interpolated over a fixed 19-point
// table. Output stream (m_axis): one result per request, in request order:
// tdata[13:0] temperature in 1/2^FRAC_BITS degree F (two's complement),
// tdata[18:14] segment used, tuser set when the input was clamped.
//
// Five register stages: clamp and segment search, numerator product, reciprocal
// multiply, remainder correction, temperature assembly. A result is presented
// from the last of them; one request per cycle is taken when the output side
// keeps up. Every stage takes one item per cycle, so only the receiver limits
// throughput.
// Each stage holds its item while the next one is full, so a stalled receiver
// back-pressures stage by stage; empty stages still fill, nothing is dropped.
// Reset (synchronous, active low) empties the pipeline; there is no other state.
module sensor_voltage_to_temperature_unit #(
    parameter int FRAC_BITS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [12:0] sensor_millivolts, [15:13] zero
    input  logic [svtt_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [13:0] temperature_sixteenths, [18:14] segment_index, [23:19] zero
    output logic [svtt_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // [0] input_clamped
    output logic                              o_m_axis_tuser
);
    import svtt_pkg::*;

    localparam int Q_W    = DT_W + FRAC_BITS;
    localparam int TEMP_W = (DEGF_W + FRAC_BITS > TEMP_OUT_W) ?
                            (DEGF_W + FRAC_BITS) : TEMP_OUT_W;

    logic            w_seg_valid, w_seg_ready;
    t_seg_item       w_seg_item;
    logic            w_q_valid, w_q_ready;
    logic [Q_W-1:0]  w_q;
    t_tag            w_q_tag;

    logic                   r_e_valid;
    logic [TEMP_OUT_W-1:0]  r_e_temp;
    t_tag                   r_e_tag;
    logic [TEMP_W-1:0]      n_e_base;
    logic [TEMP_W-1:0]      n_e_temp;

    svtt_seg u_seg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_mv    (i_s_axis_tdata[MV_W-1:0]),
        .o_ready (o_s_axis_tready),
        .o_valid (w_seg_valid),
        .o_item  (w_seg_item),
        .i_ready (w_seg_ready)
    );

    svtt_quot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_quot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_seg_valid),
        .i_item  (w_seg_item),
        .o_ready (w_seg_ready),
        .o_valid (w_q_valid),
        .o_q     (w_q),
        .o_tag   (w_q_tag),
        .i_ready (w_q_ready)
    );

    assign w_q_ready = !r_e_valid || i_m_axis_tready;

    always_comb begin
        n_e_base = TEMP_W'(BP_DEGF[w_q_tag.k]);
        n_e_temp = (n_e_base << FRAC_BITS) - TEMP_W'(w_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (w_q_ready) begin
            r_e_valid <= w_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_q_valid && w_q_ready) begin
            r_e_temp <= n_e_temp[TEMP_OUT_W-1:0];
            r_e_tag  <= w_q_tag;
        end
    end

    assign o_m_axis_tvalid = r_e_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - TEMP_OUT_W - SEG_W)'(0), r_e_tag.k, r_e_temp};
    assign o_m_axis_tuser  = r_e_tag.clamped;

endmodule

// ===== rtl/svtt_seg.sv =====
`timescale 1ns / 1ps
// Input stage: clamps the voltage and selects the table segment.
module svtt_seg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  svtt_pkg::t_mv         i_mv,
    output logic                  o_ready,
    output logic                  o_valid,
    output svtt_pkg::t_seg_item   o_item,
    input  logic                  i_ready
);
    import svtt_pkg::*;

    logic      r_valid;
    t_seg_item r_item;
    t_seg_item n_item;

    always_comb begin
        n_item.v           = i_mv;
        n_item.tag.clamped = 1'b0;
        if (i_mv < V_MIN_MV) begin
            n_item.v           = V_MIN_MV;
            n_item.tag.clamped = 1'b1;
        end else if (i_mv > V_MAX_MV) begin
            n_item.v           = V_MAX_MV;
            n_item.tag.clamped = 1'b1;
        end
        n_item.tag.k = SEG_W'(SEG_CNT - 1);
        for (int s = SEG_CNT - 2; s >= 0; s--) begin
            if (n_item.v <= BP_MV[s+1]) begin
                n_item.tag.k = SEG_W'(s);
            end
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/svtt_quot.sv =====
`timescale 1ns / 1ps
// Interpolation quotient: numerator product, reciprocal multiply, remainder correction.
module svtt_quot #(
    parameter int FRAC_BITS = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  svtt_pkg::t_seg_item        i_item,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic [svtt_pkg::DT_W+FRAC_BITS-1:0] o_q,
    output svtt_pkg::t_tag             o_tag,
    input  logic                       i_ready
);
    import svtt_pkg::*;

    localparam int N_W   = PROD_W + FRAC_BITS;
    localparam int Q_W   = DT_W + FRAC_BITS;
    localparam int MUL_W = N_W + RECIP_W;

    logic w_rdy_b, w_rdy_c, w_rdy_d;

    // stage B
    logic                     r_b_valid;
    logic [PROD_W-1:0]        r_b_n;
    t_tag                     r_b_tag;
    logic [DIFF_W-1:0]        n_b_diff;
    logic [DIFF_W+DT_W-1:0]   n_b_full;

    // stage C
    logic                     r_c_valid;
    logic [N_W-1:0]           r_c_num;
    logic [Q_W-1:0]           r_c_q0;
    t_tag                     r_c_tag;
    logic [N_W-1:0]           n_c_num;
    logic [MUL_W-1:0]         n_c_mul;

    // stage D
    logic                     r_d_valid;
    logic [Q_W-1:0]           r_d_q;
    t_tag                     r_d_tag;
    logic [Q_W+DEN_W-1:0]     n_d_full;
    logic [N_W-1:0]           n_d_rem;
    logic [Q_W-1:0]           n_d_q;

    assign w_rdy_d = !r_d_valid || i_ready;
    assign w_rdy_c = !r_c_valid || w_rdy_d;
    assign w_rdy_b = !r_b_valid || w_rdy_c;
    assign o_ready = w_rdy_b;

    always_comb begin
        n_b_diff = DIFF_W'(i_item.v - BP_MV[i_item.tag.k]);
        n_b_full = n_b_diff * SEG_DT[i_item.tag.k];
    end

    always_comb begin
        n_c_num = N_W'(r_b_n) << FRAC_BITS;
        n_c_mul = n_c_num * SEG_RECIP[r_b_tag.k];
    end

    always_comb begin
        n_d_full = r_c_q0 * SEG_DEN[r_c_tag.k];
        n_d_rem  = r_c_num - n_d_full[N_W-1:0];
        if (n_d_rem >= N_W'(SEG_DEN[r_c_tag.k])) begin
            n_d_q = r_c_q0 + Q_W'(1);
        end else begin
            n_d_q = r_c_q0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (w_rdy_b) begin
                r_b_valid <= i_valid;
            end
            if (w_rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (w_rdy_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && w_rdy_b) begin
            r_b_n   <= n_b_full[PROD_W-1:0];
            r_b_tag <= i_item.tag;
        end
        if (r_b_valid && w_rdy_c) begin
            r_c_num <= n_c_num;
            r_c_q0  <= n_c_mul[RECIP_SHIFT +: Q_W];
            r_c_tag <= r_b_tag;
        end
        if (r_c_valid && w_rdy_d) begin
            r_d_q   <= n_d_q;
            r_d_tag <= r_c_tag;
        end
    end

    assign o_valid = r_d_valid;
    assign o_q     = r_d_q;
    assign o_tag   = r_d_tag;

endmodule
